// ----- rtl/sdh_pkg.sv -----
// Shared constants, codes and defaults for the shape distance histogram core.
`timescale 1ns / 1ps
package sdh_pkg;

  localparam int COORD_W   = 24;
  localparam int IDX_W     = 12;
  localparam int BINIDX_W  = 11;
  localparam int KIND_W    = 3;
  localparam int STAT_W    = 2;
  localparam int COUNT_W   = 21;
  localparam int FRAC_W    = 17;
  localparam int FRAC_SHIFT = 16;
  localparam int ABS_W     = 24;
  localparam int DSQ_W     = 50;
  localparam int SPLIT_W   = 25;
  localparam int EXT_W     = 24;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
  localparam logic [COORD_W-1:0] COORD_POS_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_NEG_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  localparam logic [KIND_W-1:0] KIND_VERTEX  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PAIR    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_COMPUTE = 3'd2;
  localparam logic [KIND_W-1:0] KIND_READ    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RESTART = 3'd4;

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_NOT_LOAD = 2'd2;
  localparam logic [STAT_W-1:0] STAT_ZERO_EXT = 2'd3;

  localparam int DEF_MAX_VERTICES = 4096;
  localparam int DEF_MAX_SAMPLES  = 1024;
  localparam int DEF_NUM_BINS     = 2048;
  localparam int DEF_BIN_SCALE    = 1000;

endpackage

// ----- rtl/sdh_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module sdh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/sdh_sqrt.sv -----
// Iterative integer square root, one result bit per cycle.
`timescale 1ns / 1ps
module sdh_sqrt #(
  parameter int ROOT_W = 35,
  localparam int RAD_W = 2 * ROOT_W,
  localparam int CNT_W = $clog2(ROOT_W + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output logic              done
);

  logic [RAD_W-1:0]  rad_sh;
  logic [ROOT_W+1:0] rem;
  logic [CNT_W-1:0]  cnt;
  logic              busy;
  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic              fits;

  assign rem_sh = {rem[ROOT_W:0], rad_sh[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root, 2'b01};
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(ROOT_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[RAD_W-3:0], 2'b00};
      rem    <= fits ? (ROOT_W+2)'(rem_sh - trial) : rem_sh[ROOT_W+1:0];
      root   <= {root[ROOT_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/sdh_div.sv -----
// Restoring serial divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module sdh_div #(
  parameter int N_W = 37,
  parameter int D_W = 24,
  localparam int CNT_W = $clog2(N_W + 1)
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [N_W-1:0] dividend,
  input  logic [D_W-1:0] divisor,
  output logic [N_W-1:0] quotient,
  output logic           done
);

  logic [N_W-1:0]   dvd;
  logic [D_W-1:0]   dvs;
  logic [D_W-1:0]   rem;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [D_W:0]     rs;
  logic             fits;

  assign rs   = {rem, dvd[N_W-1]};
  assign fits = (rs >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(N_W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (busy) begin
      dvd      <= {dvd[N_W-2:0], 1'b0};
      rem      <= fits ? D_W'(rs - {1'b0, dvs}) : rs[D_W-1:0];
      quotient <= {quotient[N_W-2:0], fits};
    end
  end

endmodule

// ----- rtl/shape_distance_histogram_core.sv -----
// Top level of the D2 shape distribution histogram core.
`timescale 1ns / 1ps
// Vertices and sample pairs load into on-chip RAMs; a compute item clears the
// histogram RAM and then, for every A sample against every B sample, squares
// the distance with one shared multiplier, scales it, takes an exact integer
// square root and divides by the largest bounding-box side to find the bin,
// which it updates read-modify-write. A read with a nonzero peak also runs
// the divider, shared with the bin step, to find the fraction. The pair loop
// is paced by the bit-serial root and divide units, and the A vertex is read
// again for each A row. After reset a clearing pass over all NUM_BINS entries
// runs before the first transfer is accepted. One item is in work at a time;
// a result waits in the output register while the next item is accepted.
module shape_distance_histogram_core
  import sdh_pkg::*;
#(
  parameter int MAX_VERTICES = DEF_MAX_VERTICES,
  parameter int MAX_SAMPLES  = DEF_MAX_SAMPLES,
  parameter int NUM_BINS     = DEF_NUM_BINS,
  parameter int BIN_SCALE    = DEF_BIN_SCALE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [KIND_W-1:0]          kind,
  input  logic signed [COORD_W-1:0]  x_coord,
  input  logic signed [COORD_W-1:0]  y_coord,
  input  logic signed [COORD_W-1:0]  z_coord,
  input  logic [IDX_W-1:0]           index_a,
  input  logic [IDX_W-1:0]           index_b,
  input  logic [BINIDX_W-1:0]        bin_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STAT_W-1:0]          status,
  output logic [COUNT_W-1:0]         bin_count,
  output logic [FRAC_W-1:0]          bin_fraction,
  output logic [COUNT_W-1:0]         peak_count
);

  localparam int VA_W   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int VC_W   = $clog2(MAX_VERTICES + 1);
  localparam int CMP_W  = (VC_W > IDX_W) ? VC_W : IDX_W;
  localparam int SA_W   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SC_W   = $clog2(MAX_SAMPLES + 1);
  localparam int HB_W   = $clog2(NUM_BINS);
  localparam int BC_W   = ((HB_W + 1) > BINIDX_W) ? (HB_W + 1) : BINIDX_W;
  localparam int SCL_W  = $clog2(BIN_SCALE * BIN_SCALE + 1);
  localparam int T_W    = SCL_W + DSQ_W;
  localparam int ROOT_W = (T_W + 1) / 2;
  localparam int FD_W   = COUNT_W + FRAC_SHIFT;
  localparam int DV_N   = (ROOT_W > FD_W) ? ROOT_W : FD_W;
  localparam int DV_D   = EXT_W;
  localparam int P_W    = SCL_W + SPLIT_W;
  localparam int V_W    = 3 * COORD_W;

  localparam logic [SCL_W-1:0] SCALE_SQ = SCL_W'(BIN_SCALE * BIN_SCALE);

  localparam logic [4:0] S_CLEAR = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_RESP  = 5'd2;
  localparam logic [4:0] S_CCLR  = 5'd3;
  localparam logic [4:0] S_RDA   = 5'd4;
  localparam logic [4:0] S_RDA2  = 5'd5;
  localparam logic [4:0] S_RDA3  = 5'd6;
  localparam logic [4:0] S_RDB   = 5'd7;
  localparam logic [4:0] S_RDB2  = 5'd8;
  localparam logic [4:0] S_PB    = 5'd9;
  localparam logic [4:0] S_SQ    = 5'd10;
  localparam logic [4:0] S_SC0   = 5'd11;
  localparam logic [4:0] S_SC1   = 5'd12;
  localparam logic [4:0] S_SQRT  = 5'd13;
  localparam logic [4:0] S_BDIV  = 5'd14;
  localparam logic [4:0] S_HRD   = 5'd15;
  localparam logic [4:0] S_HWR   = 5'd16;
  localparam logic [4:0] S_BRD2  = 5'd17;
  localparam logic [4:0] S_FDIV  = 5'd18;

  logic [4:0] state;

  logic [VC_W-1:0] vcount;
  logic [SC_W-1:0] scount;
  logic signed [COORD_W-1:0] bmin [3];
  logic signed [COORD_W-1:0] bmax [3];
  logic [COUNT_W-1:0] peak;

  logic [HB_W-1:0]  clr_addr;
  logic [SC_W-1:0]  ii;
  logic [SC_W-1:0]  jj;
  logic [EXT_W-1:0] ext_r;
  logic [V_W-1:0]   pa;
  logic [ABS_W-1:0] ad [3];
  logic [1:0]       sq_k;
  logic [DSQ_W-1:0] dsq;
  logic [T_W-1:0]   tacc;
  logic [HB_W-1:0]  bin_r;
  logic [COUNT_W-1:0] cnt_r;

  logic [STAT_W-1:0]  rsp_status;
  logic [COUNT_W-1:0] rsp_count;
  logic [FRAC_W-1:0]  rsp_frac;

  logic sq_start;
  logic dv_start;

  // memories
  logic            v_we;
  logic [VA_W-1:0] v_raddr;
  logic [V_W-1:0]  v_rdata;
  logic            s_we;
  logic [SA_W-1:0] s_raddr;
  logic [2*VA_W-1:0] s_rdata;
  logic            h_we;
  logic [HB_W-1:0] h_waddr;
  logic [COUNT_W-1:0] h_wdata;
  logic [HB_W-1:0] h_raddr;
  logic [COUNT_W-1:0] h_rdata;

  logic [ROOT_W-1:0] sq_root;
  logic              sq_done;
  logic [DV_N-1:0]   dv_dividend;
  logic [DV_D-1:0]   dv_divisor;
  logic [DV_N-1:0]   dv_q;
  logic              dv_done;

  logic accept;
  logic out_free;
  logic [CMP_W-1:0] ia_ext;
  logic [CMP_W-1:0] ib_ext;
  logic [CMP_W-1:0] vc_ext;
  logic [BC_W-1:0]  bi_ext;
  logic             bin_oor;
  logic signed [COORD_W-1:0] pin [3];
  logic signed [COORD_W:0]   side [3];
  logic [EXT_W-1:0] ext_c;
  logic             ext_zero;
  logic signed [COORD_W:0]   dif [3];
  logic [ABS_W-1:0] ad_sel;
  logic [2*ABS_W-1:0] sq_prod;
  logic [SPLIT_W-1:0] sc_op;
  logic [P_W-1:0]   sc_prod;
  logic [COUNT_W-1:0] h_inc;
  logic             j_last;
  logic             i_last;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  assign ia_ext  = CMP_W'(index_a);
  assign ib_ext  = CMP_W'(index_b);
  assign vc_ext  = CMP_W'(vcount);
  assign bi_ext  = BC_W'(bin_index);
  assign bin_oor = (bi_ext >= BC_W'(NUM_BINS));

  assign pin[0] = x_coord;
  assign pin[1] = y_coord;
  assign pin[2] = z_coord;

  always_comb begin
    ext_c = '0;
    for (int k = 0; k < 3; k++) begin
      side[k] = {bmax[k][COORD_W-1], bmax[k]} - {bmin[k][COORD_W-1], bmin[k]};
      if (!side[k][COORD_W] && (EXT_W'(side[k]) > ext_c)) begin
        ext_c = EXT_W'(side[k]);
      end
    end
  end
  assign ext_zero = (vcount == '0) || (ext_c == '0);

  // per-axis difference of the A vertex and the B vertex just read
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      dif[k] = {pa[k*COORD_W + COORD_W-1], pa[k*COORD_W +: COORD_W]}
             - {v_rdata[k*COORD_W + COORD_W-1], v_rdata[k*COORD_W +: COORD_W]};
    end
  end

  always_comb begin
    case (sq_k)
      2'd0:    ad_sel = ad[0];
      2'd1:    ad_sel = ad[1];
      default: ad_sel = ad[2];
    endcase
  end
  assign sq_prod = ad_sel * ad_sel;

  assign sc_op   = (state == S_SC0) ? dsq[SPLIT_W-1:0] : SPLIT_W'(dsq[DSQ_W-1:SPLIT_W]);
  assign sc_prod = SCALE_SQ * sc_op;

  assign h_inc  = (h_rdata == COUNT_MAX) ? h_rdata : h_rdata + 1'b1;
  assign j_last = (jj == scount - 1'b1);
  assign i_last = (ii == scount - 1'b1);

  // memory port steering
  assign v_we    = accept && (kind == KIND_VERTEX) && (vcount != VC_W'(MAX_VERTICES));
  assign v_raddr = (state == S_RDA2) ? s_rdata[2*VA_W-1:VA_W] : s_rdata[VA_W-1:0];
  assign s_we    = accept && (kind == KIND_PAIR) && (ia_ext < vc_ext) && (ib_ext < vc_ext)
                   && (scount != SC_W'(MAX_SAMPLES));
  assign s_raddr = (state == S_RDA) ? ii[SA_W-1:0] : jj[SA_W-1:0];
  assign h_we    = (state == S_CLEAR) || (state == S_CCLR) || (state == S_HWR);
  assign h_waddr = (state == S_HWR) ? bin_r : clr_addr;
  assign h_wdata = (state == S_HWR) ? h_inc : '0;
  assign h_raddr = (state == S_IDLE) ? bi_ext[HB_W-1:0] : bin_r;

  assign dv_dividend = (state == S_FDIV) ? DV_N'({cnt_r, FRAC_SHIFT'(0)}) : DV_N'(sq_root);
  assign dv_divisor  = (state == S_FDIV) ? DV_D'(peak) : ext_r;

  sdh_ram #(.WIDTH(V_W), .DEPTH(MAX_VERTICES)) u_vram (
    .clk   (clk),
    .we    (v_we),
    .waddr (vcount[VA_W-1:0]),
    .wdata ({z_coord, y_coord, x_coord}),
    .raddr (v_raddr),
    .rdata (v_rdata)
  );

  sdh_ram #(.WIDTH(2*VA_W), .DEPTH(MAX_SAMPLES)) u_sram (
    .clk   (clk),
    .we    (s_we),
    .waddr (scount[SA_W-1:0]),
    .wdata ({ia_ext[VA_W-1:0], ib_ext[VA_W-1:0]}),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  sdh_ram #(.WIDTH(COUNT_W), .DEPTH(NUM_BINS)) u_hram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  sdh_sqrt #(.ROOT_W(ROOT_W)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand ((2*ROOT_W)'(tacc)),
    .root     (sq_root),
    .done     (sq_done)
  );

  sdh_div #(.N_W(DV_N), .D_W(DV_D)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (dv_start),
    .dividend (dv_dividend),
    .divisor  (dv_divisor),
    .quotient (dv_q),
    .done     (dv_done)
  );

  // control and state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_addr  <= '0;
      vcount    <= '0;
      scount    <= '0;
      peak      <= '0;
      out_valid <= 1'b0;
      sq_start  <= 1'b0;
      dv_start  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        bmin[k] <= COORD_POS_MAX;
        bmax[k] <= COORD_NEG_MIN;
      end
    end else begin
      sq_start <= 1'b0;
      dv_start <= 1'b0;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == HB_W'(NUM_BINS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            rsp_status <= STAT_OK;
            rsp_count  <= '0;
            rsp_frac   <= '0;
            state      <= S_RESP;
            case (kind)
              KIND_VERTEX: begin
                if (vcount == VC_W'(MAX_VERTICES)) begin
                  rsp_status <= STAT_FULL;
                end else begin
                  vcount <= vcount + 1'b1;
                  for (int k = 0; k < 3; k++) begin
                    if (pin[k] < bmin[k]) bmin[k] <= pin[k];
                    if (pin[k] > bmax[k]) bmax[k] <= pin[k];
                  end
                end
              end
              KIND_PAIR: begin
                if ((ia_ext >= vc_ext) || (ib_ext >= vc_ext)) begin
                  rsp_status <= STAT_NOT_LOAD;
                end else if (scount == SC_W'(MAX_SAMPLES)) begin
                  rsp_status <= STAT_FULL;
                end else begin
                  scount <= scount + 1'b1;
                end
              end
              KIND_COMPUTE: begin
                ext_r    <= ext_c;
                clr_addr <= '0;
                state    <= S_CCLR;
                if (ext_zero) begin
                  rsp_status <= STAT_ZERO_EXT;
                end
              end
              KIND_READ: begin
                if (bin_oor) begin
                  rsp_status <= STAT_NOT_LOAD;
                end else begin
                  state <= S_BRD2;
                end
              end
              KIND_RESTART: begin
                vcount <= '0;
                scount <= '0;
                for (int k = 0; k < 3; k++) begin
                  bmin[k] <= COORD_POS_MAX;
                  bmax[k] <= COORD_NEG_MIN;
                end
              end
              default: ;
            endcase
          end
        end
        S_RESP: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= rsp_status;
            bin_count    <= rsp_count;
            bin_fraction <= rsp_frac;
            peak_count   <= peak;
            state        <= S_IDLE;
          end
        end
        S_CCLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == HB_W'(NUM_BINS - 1)) begin
            peak <= '0;
            ii   <= '0;
            if ((rsp_status == STAT_ZERO_EXT) || (scount == '0)) begin
              state <= S_RESP;
            end else begin
              state <= S_RDA;
            end
          end
        end
        S_RDA:  state <= S_RDA2;
        S_RDA2: state <= S_RDA3;
        S_RDA3: begin
          pa    <= v_rdata;
          jj    <= '0;
          state <= S_RDB;
        end
        S_RDB:  state <= S_RDB2;
        S_RDB2: state <= S_PB;
        S_PB: begin
          for (int k = 0; k < 3; k++) begin
            ad[k] <= dif[k][COORD_W] ? ABS_W'(-dif[k]) : ABS_W'(dif[k]);
          end
          dsq   <= '0;
          sq_k  <= '0;
          state <= S_SQ;
        end
        S_SQ: begin
          dsq  <= dsq + DSQ_W'(sq_prod);
          sq_k <= sq_k + 1'b1;
          if (sq_k == 2'd2) begin
            state <= S_SC0;
          end
        end
        S_SC0: begin
          tacc  <= T_W'(sc_prod);
          state <= S_SC1;
        end
        S_SC1: begin
          tacc     <= tacc + (T_W'(sc_prod) << SPLIT_W);
          sq_start <= 1'b1;
          state    <= S_SQRT;
        end
        S_SQRT: begin
          if (sq_done) begin
            dv_start <= 1'b1;
            state    <= S_BDIV;
          end
        end
        S_BDIV: begin
          if (dv_done) begin
            // clamp to the last bin
            bin_r <= (dv_q > DV_N'(NUM_BINS - 1)) ? HB_W'(NUM_BINS - 1) : dv_q[HB_W-1:0];
            state <= S_HRD;
          end
        end
        S_HRD: state <= S_HWR;
        S_HWR: begin
          if (h_inc > peak) begin
            peak <= h_inc;
          end
          if (j_last) begin
            if (i_last) begin
              state <= S_RESP;
            end else begin
              ii    <= ii + 1'b1;
              state <= S_RDA;
            end
          end else begin
            jj    <= jj + 1'b1;
            state <= S_RDB;
          end
        end
        S_BRD2: begin
          cnt_r     <= h_rdata;
          rsp_count <= h_rdata;
          if (peak == '0) begin
            state <= S_RESP;
          end else begin
            dv_start <= 1'b1;
            state    <= S_FDIV;
          end
        end
        S_FDIV: begin
          if (dv_done) begin
            rsp_frac <= dv_q[FRAC_W-1:0];
            state    <= S_RESP;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/sdh_checker.sv -----
// Port-level checks for the shape distance histogram core, bound to the top.
`timescale 1ns / 1ps
module sdh_checker
  import sdh_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [STAT_W-1:0]         status,
  input logic [COUNT_W-1:0]        bin_count,
  input logic [FRAC_W-1:0]         bin_fraction,
  input logic [COUNT_W-1:0]        peak_count
);

  // an offered input transfer stays offered until taken
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid)
    else $error("input transfer withdrawn");

  // a stalled result holds its valid, status and count
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(bin_count))
    else $error("result changed while stalled");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != STAT_OK) |-> (bin_count == '0) && (bin_fraction == '0))
    else $error("nonzero count on error status");

  a_count_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bin_count <= peak_count)
    else $error("bin count above peak");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (bin_fraction <= FRAC_W'(1 << FRAC_SHIFT))
                  && ((peak_count != '0) || (bin_fraction == '0)))
    else $error("fraction out of range");

endmodule

bind shape_distance_histogram_core sdh_checker u_sdh_checker (.*);
